FILE: rtl/rchc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rchc_pkg
// Shared types, widths and codes of the ray against convex hull clip unit.
// ---------------------------------------------------------------------------
package rchc_pkg;

    // default table depth
    localparam int MAX_FACES_DEF = 64;

    // field widths
    localparam int W_Q        = 32;          // signed q16.16 value
    localparam int W_DLT      = 33;          // end minus start
    localparam int W_PROD     = W_Q + W_DLT; // full product
    localparam int W_QM       = W_PROD - 16; // product scaled back to q16.16
    localparam int W_ACC      = 52;          // distance and denominator
    localparam int W_DIV      = W_ACC + 31;  // divider remainder and divisor
    localparam int W_T        = 33;          // signed ray parameter
    localparam int W_FC       = 7;           // face count register
    localparam int W_MA       = 31;          // max alpha register
    localparam int W_IDX      = 6;           // plane index / hit face
    localparam int W_STATUS   = 2;
    localparam int W_IN_DATA  = 328;
    localparam int W_OUT_DATA = 232;

    // configuration register indexes
    localparam logic CFG_FACE_COUNT = 1'b0;
    localparam logic CFG_MAX_ALPHA  = 1'b1;

    // input commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_CAST = 1'b1;

    // result status
    typedef enum logic [W_STATUS-1:0] {
        ST_MISS   = 2'd0,
        ST_HIT    = 2'd1,
        ST_INSIDE = 2'd2
    } t_status;

    // one table entry
    typedef struct packed {
        logic signed [W_Q-1:0] off;
        logic signed [W_Q-1:0] nz;
        logic signed [W_Q-1:0] ny;
        logic signed [W_Q-1:0] nx;
    } t_plane;

    // cast sequencer
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_CHK   = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_POINT = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

endpackage

FILE: rtl/rchc_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rchc_div
// Iterative signed divider: num * 65536 / den, magnitude truncated and
// saturated to 2^31, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rchc_div import rchc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [W_ACC-1:0] i_num,
    input  logic signed [W_ACC-1:0] i_den,
    output logic                    o_done,
    output logic signed [W_T-1:0]   o_quot
);

    logic             r_busy;
    logic             r_done;
    logic             r_neg;
    logic [4:0]       r_bit;
    logic [W_DIV-1:0] r_rem;
    logic [W_DIV-1:0] r_dvs;
    logic [31:0]      r_quo;

    logic [W_ACC-1:0] mag_num;
    logic [W_ACC-1:0] mag_den;
    logic             ge;
    logic             finish;

    // operand magnitudes
    assign mag_num = i_num[W_ACC-1] ? W_ACC'(-i_num) : W_ACC'(i_num);
    assign mag_den = i_den[W_ACC-1] ? W_ACC'(-i_den) : W_ACC'(i_den);

    assign ge     = (r_rem >= r_dvs);
    assign finish = ((r_bit == 5'd31) && ge) || (r_bit == 5'd0);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && finish) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // restoring division, top bit doubles as the saturation test
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {{(W_DIV-W_ACC-16){1'b0}}, mag_num, 16'h0000};
            r_dvs <= {mag_den, 31'd0};
            r_bit <= 5'd31;
            r_quo <= 32'd0;
            r_neg <= i_num[W_ACC-1] ^ i_den[W_ACC-1];
        end else if (r_busy) begin
            if (r_bit == 5'd31) begin
                if (ge) begin
                    r_quo <= 32'h8000_0000;
                end
            end else if (ge) begin
                r_rem        <= r_rem - r_dvs;
                r_quo[r_bit] <= 1'b1;
            end
            r_dvs <= r_dvs >> 1;
            r_bit <= r_bit - 5'd1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

endmodule

FILE: rtl/ray_convex_hull_clip_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ray_convex_hull_clip_unit
// Clips a ray segment against a convex hull held as a table of planes.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one item: tuser is the command (load plane / cast ray),
//   tdata the plane index, plane and segment. A load writes the plane table
//   in the cycle it is taken. A cast walks faces 0 .. face_count-1, capped
//   at MAX_FACES, and sends one result item on m_axis: tuser is the status,
//   tdata time, point, normal and face. Loads give no result.
//   A cast reads each face and runs the bit-serial divider for every
//   non-parallel face, then on a hit computes the hit point; the walk stops
//   early on a miss. One table read and six products through one shared
//   multiplier per face. The divider, one quotient bit a cycle, sets the
//   pace.
//   s_axis_tready is high only while no cast is in work. A finished result
//   sits in the output register; a new item is taken while it waits, and a
//   later cast holds at its end until the output register is free.
//   Reset clears the sequencer, the output register and the configuration
//   (face_count 0, max_alpha 1.0); the plane table keeps its contents.
//   The user writes configuration via i_cfg_* only while idle; not enforced.
// ---------------------------------------------------------------------------
module ray_convex_hull_clip_unit import rchc_pkg::*; #(
    parameter int MAX_FACES = MAX_FACES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [W_MA-1:0]       i_cfg_data,
    // input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // plane_index, normal_x, normal_y, normal_z, plane_offset,
    // start_x, start_y, start_z, end_x, end_y, end_z, zero pad
    input  logic [W_IN_DATA-1:0]  s_axis_tdata,
    // command
    input  logic                  s_axis_tuser,
    // result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // hit_time, hit_x, hit_y, hit_z, hit_normal_x, hit_normal_y,
    // hit_normal_z, hit_face, zero pad
    output logic [W_OUT_DATA-1:0] m_axis_tdata,
    // status
    output logic [W_STATUS-1:0]   m_axis_tuser
);

    localparam int AW = $clog2(MAX_FACES);

    // configuration
    logic [W_FC-1:0] r_face_count;
    logic [W_MA-1:0] r_max_alpha;

    // plane table
    t_plane r_mem [MAX_FACES];
    t_plane r_rd;

    // sequencer
    t_state n_state;
    t_state r_state;
    logic [W_FC-1:0] r_face;
    logic [W_FC-1:0] r_last;
    logic [2:0]      r_step;

    // cast context
    logic signed [W_Q-1:0]   r_s [3];
    logic signed [W_DLT-1:0] r_d [3];
    logic signed [W_PROD-1:0] r_prod;
    logic signed [W_ACC-1:0] r_sum_s;
    logic signed [W_ACC-1:0] r_sum_d;
    logic                    r_den_neg;
    logic signed [W_T-1:0]   r_entry;
    logic signed [W_T-1:0]   r_leave;
    logic [W_FC-1:0]         r_best;
    logic                    r_best_vld;
    logic signed [W_Q-1:0]   r_hn [3];
    logic signed [W_Q-1:0]   r_hit [3];
    t_status                 r_kind;

    // output register
    logic                  r_out_vld;
    logic [W_STATUS-1:0]   r_out_status;
    logic [W_OUT_DATA-1:0] r_out_data;

    // input unpack
    logic [W_IDX-1:0]      in_idx;
    t_plane                in_plane;
    logic signed [W_Q-1:0] in_start [3];
    logic signed [W_Q-1:0] in_end [3];

    logic s_acc;
    logic m_acc;
    logic out_free;
    logic idx_ok;
    logic [W_FC-1:0] n_faces;

    logic signed [W_Q-1:0]   mul_a;
    logic signed [W_DLT-1:0] mul_b;
    logic signed [W_QM-1:0]  qm;

    logic signed [W_ACC-1:0] plane_dist;
    logic                    den_zero;
    logic                    div_start;
    logic                    div_done;
    logic signed [W_T-1:0]   div_quot;

    logic                    enter_upd;
    logic                    leave_upd;
    logic signed [W_T-1:0]   e_new;
    logic signed [W_T-1:0]   l_new;
    logic                    empty;
    logic                    last_face;
    t_state                  nf_chk;
    t_state                  nf_div;

    logic [1:0]              pt_ax;
    logic signed [W_QM:0]    pt_sum;
    logic signed [W_Q-1:0]   pt_sat;

    assign in_idx      = s_axis_tdata[5:0];
    assign in_plane.nx = s_axis_tdata[37:6];
    assign in_plane.ny = s_axis_tdata[69:38];
    assign in_plane.nz = s_axis_tdata[101:70];
    assign in_plane.off = s_axis_tdata[133:102];
    assign in_start[0] = s_axis_tdata[165:134];
    assign in_start[1] = s_axis_tdata[197:166];
    assign in_start[2] = s_axis_tdata[229:198];
    assign in_end[0]   = s_axis_tdata[261:230];
    assign in_end[1]   = s_axis_tdata[293:262];
    assign in_end[2]   = s_axis_tdata[325:294];

    // handshakes
    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc         = s_axis_tvalid & s_axis_tready;
    assign m_acc         = r_out_vld & m_axis_tready;
    assign out_free      = !r_out_vld || m_axis_tready;

    assign idx_ok  = ({26'd0, in_idx} < 32'(MAX_FACES));
    assign n_faces = (32'(r_face_count) > 32'(MAX_FACES)) ? W_FC'(MAX_FACES) : r_face_count;

    // plane table write and registered read
    always_ff @(posedge i_clk) begin
        if (s_acc && (s_axis_tuser == CMD_LOAD) && idx_ok) begin
            r_mem[AW'(in_idx)] <= in_plane;
        end
        if (r_state == S_READ) begin
            r_rd <= r_mem[AW'(r_face)];
        end
    end

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_MUL) begin
            case (r_step)
                3'd0: begin mul_a = r_rd.nx; mul_b = W_DLT'(r_s[0]); end
                3'd1: begin mul_a = r_rd.ny; mul_b = W_DLT'(r_s[1]); end
                3'd2: begin mul_a = r_rd.nz; mul_b = W_DLT'(r_s[2]); end
                3'd3: begin mul_a = r_rd.nx; mul_b = r_d[0]; end
                3'd4: begin mul_a = r_rd.ny; mul_b = r_d[1]; end
                3'd5: begin mul_a = r_rd.nz; mul_b = r_d[2]; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if (r_state == S_POINT) begin
            mul_a = $signed({1'b0, r_entry[W_MA-1:0]});
            case (r_step)
                3'd0: mul_b = r_d[0];
                3'd1: mul_b = r_d[1];
                3'd2: mul_b = r_d[2];
                default: mul_b = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // floor of product over 65536
    assign qm = r_prod[W_PROD-1:16];

    // plane test
    assign plane_dist = W_ACC'(r_rd.off) - r_sum_s;
    assign den_zero   = (r_sum_d == '0);
    assign div_start  = (r_state == S_CHK) && !den_zero;

    rchc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (plane_dist),
        .i_den   (r_sum_d),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // interval update
    assign enter_upd = r_den_neg && (div_quot > r_entry);
    assign leave_upd = !r_den_neg && (div_quot < r_leave);
    assign e_new     = enter_upd ? div_quot : r_entry;
    assign l_new     = leave_upd ? div_quot : r_leave;
    assign empty     = (e_new > l_new);
    assign last_face = (r_face == r_last);
    assign nf_chk    = last_face ? (r_best_vld ? S_POINT : S_FIN) : S_READ;
    assign nf_div    = last_face ? ((r_best_vld || enter_upd) ? S_POINT : S_FIN) : S_READ;

    // hit point with saturation
    assign pt_ax  = 2'(r_step - 3'd1);
    assign pt_sum = (W_QM+1)'(r_s[pt_ax]) + (W_QM+1)'(qm);
    always_comb begin
        if (pt_sum > (W_QM+1)'(64'sd2147483647)) begin
            pt_sat = 32'sh7FFF_FFFF;
        end else if (pt_sum < -(W_QM+1)'(64'sd2147483648)) begin
            pt_sat = 32'sh8000_0000;
        end else begin
            pt_sat = pt_sum[W_Q-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_acc && (s_axis_tuser == CMD_CAST)) begin
                    n_state = (n_faces == '0) ? S_FIN : S_READ;
                end
            end
            S_READ:  n_state = S_MUL;
            S_MUL:   n_state = (r_step == 3'd6) ? S_CHK : S_MUL;
            S_CHK: begin
                if (den_zero) begin
                    n_state = plane_dist[W_ACC-1] ? S_FIN : nf_chk;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = empty ? S_FIN : nf_div;
                end
            end
            S_POINT: n_state = (r_step == 3'd3) ? S_FIN : S_POINT;
            S_FIN:   n_state = out_free ? S_IDLE : S_FIN;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_vld    <= 1'b0;
            r_face_count <= '0;
            r_max_alpha  <= W_MA'(65536);
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FACE_COUNT: r_face_count <= i_cfg_data[W_FC-1:0];
                    CFG_MAX_ALPHA:  r_max_alpha  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (m_acc) begin
                r_out_vld <= 1'b0;
            end
            if ((r_state == S_FIN) && out_free) begin
                r_out_vld <= 1'b1;
            end
        end
    end

    // cast datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (s_acc && (s_axis_tuser == CMD_CAST)) begin
                    for (int k = 0; k < 3; k++) begin
                        r_s[k] <= in_start[k];
                        r_d[k] <= W_DLT'(in_end[k]) - W_DLT'(in_start[k]);
                    end
                    r_entry    <= '0;
                    r_leave    <= $signed({2'b00, r_max_alpha});
                    r_best_vld <= 1'b0;
                    r_best     <= '0;
                    r_face     <= '0;
                    r_last     <= n_faces - W_FC'(1);
                    r_kind     <= ST_INSIDE;
                end
            end
            S_READ: begin
                r_step <= 3'd0;
            end
            S_MUL: begin
                r_step <= r_step + 3'd1;
                if (r_step == 3'd0) begin
                    r_sum_s <= '0;
                    r_sum_d <= '0;
                end else if (r_step <= 3'd3) begin
                    r_sum_s <= r_sum_s + W_ACC'(qm);
                end else begin
                    r_sum_d <= r_sum_d + W_ACC'(qm);
                end
            end
            S_CHK: begin
                r_den_neg <= r_sum_d[W_ACC-1];
                r_step    <= 3'd0;
                if (den_zero) begin
                    if (plane_dist[W_ACC-1]) begin
                        r_kind <= ST_MISS;
                    end else if (!last_face) begin
                        r_face <= r_face + W_FC'(1);
                    end
                end
            end
            S_DIV: begin
                r_step <= 3'd0;
                if (div_done) begin
                    r_entry <= e_new;
                    r_leave <= l_new;
                    if (enter_upd) begin
                        r_best     <= r_face;
                        r_best_vld <= 1'b1;
                        r_hn[0]    <= r_rd.nx;
                        r_hn[1]    <= r_rd.ny;
                        r_hn[2]    <= r_rd.nz;
                    end
                    if (empty) begin
                        r_kind <= ST_MISS;
                    end else if (!last_face) begin
                        r_face <= r_face + W_FC'(1);
                    end
                end
            end
            S_POINT: begin
                r_step <= r_step + 3'd1;
                if (r_step != 3'd0) begin
                    r_hit[pt_ax] <= pt_sat;
                end
                if (r_step == 3'd3) begin
                    r_kind <= ST_HIT;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    r_out_status <= r_kind;
                    case (r_kind)
                        ST_HIT: begin
                            r_out_data <= {3'b000, r_best[W_IDX-1:0],
                                           r_hn[2], r_hn[1], r_hn[0],
                                           r_hit[2], r_hit[1], r_hit[0],
                                           r_entry[W_MA-1:0]};
                        end
                        ST_INSIDE: begin
                            r_out_data <= {3'b000, {W_IDX{1'b0}}, {(3*W_Q){1'b0}},
                                           r_s[2], r_s[1], r_s[0], {W_MA{1'b0}}};
                        end
                        default: r_out_data <= '0;
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

endmodule
